// File: hdl/twd_pkg.sv
package twd_pkg;

  // Geometry table shape
  localparam int SECTORS         = 6;
  localparam int LAYERS          = 36;
  localparam int WIRES_PER_LAYER = 192;
  localparam int TABLE_DEPTH     = SECTORS * LAYERS * WIRES_PER_LAYER;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int SEC_IW          = (SECTORS > 1) ? $clog2(SECTORS) : 1;

  // Queue between front and back, power of two
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CRED_W = $clog2(QDEPTH + 1);

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Q16.16 answer constants
  localparam logic signed [31:0] MISSING_DIST = 32'sh03E7_0000;  // 999.0
  localparam logic signed [31:0] DIST_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DIST_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_PARALLEL = 2'd2
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [2:0]         sector;
    logic [5:0]         layer;
    logic [7:0]         wire_req;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] distance;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t mid;
    vec3_t dir;
  } geo_t;

  localparam int GEO_W = $bits(geo_t);

  // One query handed from front to back
  typedef struct packed {
    logic  missing;
    vec3_t pos;
    vec3_t dir;
    geo_t  geo;
  } q_item_t;

endpackage

// File: hdl/twd_ram.sv
module twd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/twd_front.sv
module twd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  twd_pkg::in_item_t item,
  input  logic              q_pop,
  output logic              q_push,
  output twd_pkg::q_item_t  q_data
);
  import twd_pkg::*;

  logic              accept;
  logic [CRED_W-1:0] used;
  logic [CRED_W-1:0] used_next;
  logic              in_range;
  logic [2:0]        sec_m1;
  logic [5:0]        lay_m1;
  logic [7:0]        wir_m1;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  idx_in;

  logic              a_valid;
  in_item_t          a_item;
  logic [IDX_W-1:0]  a_idx;
  logic              a_in_range;
  logic [SEC_IW-1:0] a_sec;
  logic              a_load;
  logic              a_have;

  logic [SECTORS-1:0] sector_loaded;

  logic              b_valid;
  logic              b_missing;
  vec3_t             b_pos;
  vec3_t             b_dir;
  geo_t              wr_geo;
  logic [GEO_W-1:0]  rdata;

  // Admit a query only while the queue has a slot reserved for it
  assign full   = (used >= CRED_W'(QDEPTH));
  assign accept = push && !full;
  assign used_next = used + CRED_W'(accept && (item.mode == MODE_QUERY)) - CRED_W'(q_pop);

  // Range check and flat table index
  always_comb begin
    in_range = (item.sector >= 3'd1) && (32'(item.sector) <= SECTORS) &&
               (item.layer >= 6'd1) && (32'(item.layer) <= LAYERS) &&
               (item.wire_req >= 8'd1) && (32'(item.wire_req) <= WIRES_PER_LAYER);
    sec_m1 = item.sector - 3'd1;
    lay_m1 = item.layer - 6'd1;
    wir_m1 = item.wire_req - 8'd1;
    row    = IDX_W'(sec_m1) * IDX_W'(LAYERS) + IDX_W'(lay_m1);
    idx_in = row * IDX_W'(WIRES_PER_LAYER) + IDX_W'(wir_m1);
  end

  // Table access stage
  assign a_sec  = SEC_IW'(a_item.sector - 3'd1);
  assign a_load = a_valid && (a_item.mode == MODE_LOAD) && a_in_range;
  assign a_have = sector_loaded[a_sec];

  always_comb begin
    wr_geo.mid.x = a_item.pos_x;
    wr_geo.mid.y = a_item.pos_y;
    wr_geo.mid.z = a_item.pos_z;
    wr_geo.dir.x = a_item.dir_x;
    wr_geo.dir.y = a_item.dir_y;
    wr_geo.dir.z = a_item.dir_z;
  end

  twd_ram #(
    .WIDTH (GEO_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (a_load),
    .waddr (a_idx),
    .wdata (wr_geo),
    .raddr (a_idx),
    .rdata (rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      sector_loaded <= '0;
    end else begin
      used    <= used_next;
      a_valid <= accept;
      b_valid <= a_valid && (a_item.mode == MODE_QUERY);
      if (a_load) begin
        sector_loaded[a_sec] <= 1'b1;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    a_item     <= item;
    a_idx      <= idx_in;
    a_in_range <= in_range;
    b_missing  <= !a_in_range || !a_have;
    b_pos      <= '{x: a_item.pos_x, y: a_item.pos_y, z: a_item.pos_z};
    b_dir      <= '{x: a_item.dir_x, y: a_item.dir_y, z: a_item.dir_z};
  end

  // Hand the query with its wire entry to the queue
  assign q_push = b_valid;
  always_comb begin
    q_data.missing = b_missing;
    q_data.pos     = b_pos;
    q_data.dir     = b_dir;
    q_data.geo     = geo_t'(rdata);
  end

endmodule

// File: hdl/twd_queue.sv
module twd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  twd_pkg::q_item_t wdata,
  input  logic             pop,
  output logic             valid,
  output twd_pkg::q_item_t rdata
);
  import twd_pkg::*;

  q_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [CRED_W-1:0] count;

  assign valid = (count != '0);
  assign rdata = mem[rptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CRED_W'(push) - CRED_W'(pop);
    end
  end

  // Store one beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: hdl/twd_back.sv
module twd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  twd_pkg::q_item_t   q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output twd_pkg::out_item_t result
);
  import twd_pkg::*;

  localparam int ROOT_W = 32;
  localparam int QUO_W  = 33;

  typedef struct packed {
    logic               valid;
    logic               missing;
    vec3_t              d;
    logic signed [63:0] wy_dz;
    logic signed [63:0] wz_dy;
    logic signed [63:0] wz_dx;
    logic signed [63:0] wx_dz;
    logic signed [63:0] wx_dy;
    logic signed [63:0] wy_dx;
  } s1_t;

  typedef struct packed {
    logic  valid;
    logic  missing;
    vec3_t d;
    vec3_t c;
  } s2_t;

  typedef struct packed {
    logic               valid;
    logic               missing;
    logic signed [63:0] sq_x;
    logic signed [63:0] sq_y;
    logic signed [63:0] sq_z;
    logic signed [63:0] dc_x;
    logic signed [63:0] dc_y;
    logic signed [63:0] dc_z;
  } s3_t;

  typedef struct packed {
    logic        valid;
    logic        missing;
    logic        neg;
    logic [47:0] an;
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic        valid;
    logic        missing;
    logic        zero;
    logic        ovf;
    logic        neg;
    logic [32:0] num;
    logic [31:0] rem;
    logic [31:0] div;
    logic [32:0] quo;
  } dv_t;

  // Q32.32 product back to Q16.16, truncating toward zero
  function automatic logic signed [47:0] trunc_q(input logic signed [63:0] p);
    logic signed [63:0] biased;
    biased = p + (p[63] ? 64'sd65535 : 64'sd0);
    return biased[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = DIST_MAX;
    end else if (v < -49'sd2147483648) begin
      r = DIST_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // One root bit per step
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    r      = s;
    rem_sh = {s.rem[33:0], s.rad[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    r.rad  = {s.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit per step
  function automatic dv_t div_step(input dv_t s);
    dv_t         r;
    logic [32:0] r2;
    logic [32:0] diff;
    r     = s;
    r2    = {s.rem, s.num[32]};
    diff  = r2 - {1'b0, s.div};
    r.num = {s.num[31:0], 1'b0};
    if (r2 >= {1'b0, s.div}) begin
      r.rem = diff[31:0];
      r.quo = {s.quo[31:0], 1'b1};
    end else begin
      r.rem = r2[31:0];
      r.quo = {s.quo[31:0], 1'b0};
    end
    return r;
  endfunction

  logic      en;
  logic      res_valid;
  s1_t       s1, s1_next;
  s2_t       s2, s2_next;
  s3_t       s3, s3_next;
  sq_t       sq0_next;
  dv_t       dv0_next;
  sq_t       sqs [ROOT_W+1];
  dv_t       dvs [QUO_W+1];
  dv_t       fin;
  out_item_t res_next;
  logic signed [49:0] num;
  logic [63:0] dvd;

  // Hold the whole back end while a result waits
  assign en    = !res_valid || pop;
  assign q_pop = en && q_valid;
  assign empty = !res_valid;

  // Cross product terms and offset from wire midpoint
  always_comb begin
    s1_next.valid   = q_valid;
    s1_next.missing = q_data.missing;
    s1_next.d.x = sat32(49'(q_data.pos.x) - 49'(q_data.geo.mid.x));
    s1_next.d.y = sat32(49'(q_data.pos.y) - 49'(q_data.geo.mid.y));
    s1_next.d.z = sat32(49'(q_data.pos.z) - 49'(q_data.geo.mid.z));
    s1_next.wy_dz = q_data.geo.dir.y * q_data.dir.z;
    s1_next.wz_dy = q_data.geo.dir.z * q_data.dir.y;
    s1_next.wz_dx = q_data.geo.dir.z * q_data.dir.x;
    s1_next.wx_dz = q_data.geo.dir.x * q_data.dir.z;
    s1_next.wx_dy = q_data.geo.dir.x * q_data.dir.y;
    s1_next.wy_dx = q_data.geo.dir.y * q_data.dir.x;
  end

  // Combine into the cross product, saturated
  always_comb begin
    s2_next.valid   = s1.valid;
    s2_next.missing = s1.missing;
    s2_next.d       = s1.d;
    s2_next.c.x = sat32(49'(trunc_q(s1.wy_dz)) - 49'(trunc_q(s1.wz_dy)));
    s2_next.c.y = sat32(49'(trunc_q(s1.wz_dx)) - 49'(trunc_q(s1.wx_dz)));
    s2_next.c.z = sat32(49'(trunc_q(s1.wx_dy)) - 49'(trunc_q(s1.wy_dx)));
  end

  // Squares for the magnitude, products for the dot
  always_comb begin
    s3_next.valid   = s2.valid;
    s3_next.missing = s2.missing;
    s3_next.sq_x = s2.c.x * s2.c.x;
    s3_next.sq_y = s2.c.y * s2.c.y;
    s3_next.sq_z = s2.c.z * s2.c.z;
    s3_next.dc_x = s2.d.x * s2.c.x;
    s3_next.dc_y = s2.d.y * s2.c.y;
    s3_next.dc_z = s2.d.z * s2.c.z;
  end

  // Sum of squares and dot product, split into sign and magnitude
  always_comb begin
    num = 50'(trunc_q(s3.dc_x)) + 50'(trunc_q(s3.dc_y)) + 50'(trunc_q(s3.dc_z));
    sq0_next.valid   = s3.valid;
    sq0_next.missing = s3.missing;
    sq0_next.neg     = num[49];
    sq0_next.an      = num[49] ? 48'(-num) : num[47:0];
    sq0_next.rad     = $unsigned(s3.sq_x) + $unsigned(s3.sq_y) + $unsigned(s3.sq_z);
    sq0_next.rem     = '0;
    sq0_next.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid     <= 1'b0;
      s2.valid     <= 1'b0;
      s3.valid     <= 1'b0;
      sqs[0].valid <= 1'b0;
    end else if (en) begin
      s1     <= s1_next;
      s2     <= s2_next;
      s3     <= s3_next;
      sqs[0] <= sq0_next;
    end
  end

  // Square root pipeline
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sqs[k+1].valid <= 1'b0;
      end else if (en) begin
        sqs[k+1] <= sqrt_step(sqs[k]);
      end
    end
  end

  // Set up the divide and flag quotient overflow
  always_comb begin
    dvd = {sqs[ROOT_W].an, 16'b0};
    dv0_next.valid   = sqs[ROOT_W].valid;
    dv0_next.missing = sqs[ROOT_W].missing;
    dv0_next.neg     = sqs[ROOT_W].neg;
    dv0_next.zero    = (sqs[ROOT_W].root == '0);
    dv0_next.ovf     = ({1'b0, dvd[63:33]} >= sqs[ROOT_W].root);
    dv0_next.num     = dvd[32:0];
    dv0_next.rem     = {1'b0, dvd[63:33]};
    dv0_next.div     = sqs[ROOT_W].root;
    dv0_next.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvs[0].valid <= 1'b0;
    end else if (en) begin
      dvs[0] <= dv0_next;
    end
  end

  // Divider pipeline
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvs[k+1].valid <= 1'b0;
      end else if (en) begin
        dvs[k+1] <= div_step(dvs[k]);
      end
    end
  end

  // Apply sign, saturate and pick the answer
  assign fin = dvs[QUO_W];
  always_comb begin
    priority if (fin.missing) begin
      res_next.distance = MISSING_DIST;
      res_next.status   = ST_MISSING;
    end else if (fin.zero) begin
      res_next.distance = DIST_MAX;
      res_next.status   = ST_PARALLEL;
    end else if (fin.neg) begin
      res_next.distance = (fin.ovf || fin.quo > 33'h0_8000_0000) ? DIST_MIN
                                                                  : -$signed(fin.quo[31:0]);
      res_next.status   = ST_OK;
    end else begin
      res_next.distance = (fin.ovf || fin.quo > 33'h0_7FFF_FFFF) ? DIST_MAX
                                                                  : $signed(fin.quo[31:0]);
      res_next.status   = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// File: hdl/track_wire_doca.sv
// A query's result shows after the table stages, the queue and the back end's arithmetic.
// One item per cycle while full is low, loads and queries mixed; loads give no result.
// The back pipeline stalls as a whole while its output register is not taken; an
// 8-entry queue between table lookup and arithmetic keeps the front taking items.
// Reset clears the sector flags, the queue and all valid state; the wire table is not
// cleared and an entry reads as undefined until loaded.
module track_wire_doca (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  twd_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output twd_pkg::out_item_t result
);
  import twd_pkg::*;

  logic    q_push;
  logic    q_valid;
  logic    q_pop;
  q_item_t q_wdata;
  q_item_t q_rdata;

  twd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_pop  (q_pop),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  twd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  twd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// File: hdl/twd_checker.sv
module twd_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input twd_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input twd_pkg::out_item_t result
);
  import twd_pkg::*;

  logic [7:0] outstanding;

  // Count queries accepted but not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(push && !full && (item.mode == MODE_QUERY))
                                 - 8'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 8'd0) |-> empty)
    else $error("result shown with no query outstanding");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  a_missing_dist: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_MISSING) |-> (result.distance == MISSING_DIST))
    else $error("missing sector without 999.0");

  a_parallel_dist: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_PARALLEL) |-> (result.distance == DIST_MAX))
    else $error("parallel track without saturated distance");

endmodule

bind track_wire_doca twd_checker u_twd_checker (.*);

// File: tb/track_wire_doca_test.sv
`timescale 1ns / 100ps

module track_wire_doca_test;
  import twd_pkg::*;

  localparam int  LATENCY    = 73;
  localparam int  HOLD_LEN   = 400;
  localparam int  CYCLE_CAP  = 400000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  // wire table as seen by the checker, written entries only
  geo_t        geo_store [int];
  int          written_idx [$];
  logic [7:0]  sector_mask = '0;
  out_item_t   pending_doca [$];

  int errors = 0;
  int cycles = 0;
  int tx_gap_max = 10;
  int rx_gap_max = 10;
  bit hold_req = 1'b0;

  track_wire_doca i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #2 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic bit index_ok(input in_item_t it);
    return it.sector >= 1 && it.sector <= SECTORS && it.layer >= 1 &&
           it.layer <= LAYERS && it.wire_req >= 1 && it.wire_req <= WIRES_PER_LAYER;
  endfunction

  function automatic int flat_index(input in_item_t it);
    return ((int'(it.sector) - 1) * LAYERS + (int'(it.layer) - 1)) * WIRES_PER_LAYER +
           (int'(it.wire_req) - 1);
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, truncated toward zero
  function automatic longint fx_mul(input logic signed [31:0] a, input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p / 65536;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // the distance a query should produce against the stored wire
  function automatic out_item_t doca_of(input in_item_t it);
    out_item_t r;
    geo_t g;
    longint cx, cy, cz, ex, ey, ez, num;
    longint unsigned sq, mag, an, q;
    if (!index_ok(it) || !sector_mask[it.sector - 1]) begin
      r.distance = MISSING_DIST;
      r.status = ST_MISSING;
      return r;
    end
    g = geo_store[flat_index(it)];
    cx = sat_q(fx_mul(g.dir.y, it.dir_z) - fx_mul(g.dir.z, it.dir_y));
    cy = sat_q(fx_mul(g.dir.z, it.dir_x) - fx_mul(g.dir.x, it.dir_z));
    cz = sat_q(fx_mul(g.dir.x, it.dir_y) - fx_mul(g.dir.y, it.dir_x));
    sq = longint'(cx * cx) + longint'(cy * cy);
    sq = sq + longint'(cz * cz);
    mag = root_floor(sq);
    if (mag == 0) begin
      r.distance = DIST_MAX;
      r.status = ST_PARALLEL;
      return r;
    end
    ex = sat_q(longint'(it.pos_x) - longint'(g.mid.x));
    ey = sat_q(longint'(it.pos_y) - longint'(g.mid.y));
    ez = sat_q(longint'(it.pos_z) - longint'(g.mid.z));
    num = fx_mul(32'(ex), 32'(cx)) + fx_mul(32'(ey), 32'(cy)) + fx_mul(32'(ez), 32'(cz));
    an = (num < 0) ? longint'(-num) : num;
    q = (an << 16) / mag;
    if (num < 0) r.distance = (q > 64'h8000_0000) ? DIST_MIN : 32'(-longint'(q));
    else r.distance = (q > 64'h7FFF_FFFF) ? DIST_MAX : q[31:0];
    r.status = ST_OK;
    return r;
  endfunction

  // update the table or queue the expected answer for one accepted beat
  task automatic track_beat(input in_item_t it);
    int k;
    if (it.mode == MODE_LOAD) begin
      if (index_ok(it)) begin
        k = flat_index(it);
        if (!geo_store.exists(k)) written_idx.push_back(k);
        geo_store[k] = {it.pos_x, it.pos_y, it.pos_z, it.dir_x, it.dir_y, it.dir_z};
        sector_mask[it.sector - 1] = 1'b1;
      end
    end else begin
      pending_doca.push_back(doca_of(it));
    end
  endtask

  // offer one beat after a random gap, hold it until taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    track_beat(it);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        stall = HOLD_LEN;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
        pop <= 1'b1;
      end else if (!pop) begin
        @(negedge clk);
        pop <= 1'b1;
      end
      do @(posedge clk); while (empty);
    end
  end

  // compare each beat taken against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_doca.size() == 0) begin
        report($sformatf("unexpected result %h/%0d", result.distance, result.status));
      end else begin
        want = pending_doca.pop_front();
        if (result.distance !== want.distance)
          report($sformatf("distance %h, want %h", result.distance, want.distance));
        if (result.status !== want.status)
          report($sformatf("status %0d, want %0d", result.status, want.status));
      end
    end
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      2: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      3: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
      4: return ($urandom_range(0, 1)) ? DIST_MAX : DIST_MIN;
      default: return $signed($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  function automatic in_item_t build(input logic m, input int s, input int l, input int w,
                                     input logic signed [31:0] px, py, pz, dx, dy, dz);
    in_item_t it;
    it.mode = m;
    it.sector = 3'(s);
    it.layer = 6'(l);
    it.wire_req = 8'(w);
    {it.pos_x, it.pos_y, it.pos_z} = {px, py, pz};
    {it.dir_x, it.dir_y, it.dir_z} = {dx, dy, dz};
    return it;
  endfunction

  function automatic in_item_t rand_fields(input logic m, input int s, input int l,
                                           input int w);
    return build(m, s, l, w, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
  endfunction

  // a query that never reads an unwritten entry of a loaded sector
  function automatic in_item_t pick_query();
    in_item_t it;
    int k;
    if (written_idx.size() > 0 && $urandom_range(0, 9) < 8) begin
      k = written_idx[$urandom_range(0, written_idx.size() - 1)];
      it = rand_fields(MODE_QUERY, k / (LAYERS * WIRES_PER_LAYER) + 1,
                       (k / WIRES_PER_LAYER) % LAYERS + 1, k % WIRES_PER_LAYER + 1);
      // sometimes run the track along the wire
      if ($urandom_range(0, 7) == 0)
        {it.dir_x, it.dir_y, it.dir_z} = geo_store[k].dir;
    end else begin
      it = rand_fields(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 63),
                       $urandom_range(0, 255));
      if (index_ok(it) && sector_mask[it.sector - 1] &&
          !geo_store.exists(flat_index(it)))
        it.wire_req = 8'd0;
    end
    return it;
  endfunction

  task automatic test_unloaded();
    send_item(rand_fields(MODE_QUERY, 1, 1, 1));
    send_item(rand_fields(MODE_QUERY, 6, 36, 192));
    // loads with a bad index leave every flag clear
    send_item(rand_fields(MODE_LOAD, 0, 1, 1));
    send_item(rand_fields(MODE_LOAD, 7, 1, 1));
    send_item(rand_fields(MODE_LOAD, 1, 0, 1));
    send_item(rand_fields(MODE_LOAD, 1, 37, 1));
    send_item(rand_fields(MODE_LOAD, 1, 1, 0));
    send_item(rand_fields(MODE_LOAD, 1, 1, 193));
    send_item(rand_fields(MODE_QUERY, 1, 1, 1));
  endtask

  task automatic test_geometry();
    // wire along z at x = 1, track along y through origin
    send_item(build(MODE_LOAD, 1, 1, 1, ONE, 0, 0, 0, 0, ONE));
    send_item(build(MODE_QUERY, 1, 1, 1, 0, 0, 0, 0, ONE, 0));
    send_item(build(MODE_QUERY, 1, 1, 1, 0, 0, 0, 0, -ONE, 0));
    // parallel and zero directions
    send_item(build(MODE_QUERY, 1, 1, 1, 0, ONE, 0, 0, 0, ONE));
    send_item(build(MODE_QUERY, 1, 1, 1, 0, ONE, 0, 0, 0, 0));
    // bad index, on loaded sector 1 and on sector 0
    send_item(rand_fields(MODE_QUERY, 1, 63, 1));
    send_item(rand_fields(MODE_QUERY, 1, 1, 255));
    send_item(rand_fields(MODE_QUERY, 0, 1, 1));
  endtask

  task automatic test_extremes();
    send_item(build(MODE_LOAD, 6, 36, 192, DIST_MIN, DIST_MIN, DIST_MIN,
                    DIST_MIN, DIST_MAX, DIST_MIN));
    send_item(build(MODE_QUERY, 6, 36, 192, DIST_MAX, DIST_MAX, DIST_MAX,
                    DIST_MAX, DIST_MIN, DIST_MIN));
    send_item(build(MODE_QUERY, 6, 36, 192, DIST_MIN, DIST_MAX, DIST_MIN,
                    DIST_MAX, DIST_MAX, DIST_MAX));
    send_item(build(MODE_LOAD, 3, 32, 128, DIST_MAX, 0, DIST_MIN, ONE, 0, 0));
    send_item(build(MODE_QUERY, 3, 32, 128, DIST_MIN, DIST_MAX, DIST_MAX, 0, 1, 0));
    send_item(build(MODE_QUERY, 3, 32, 128, DIST_MAX, DIST_MIN, DIST_MIN, 0, -1, 1));
    send_item(build(MODE_QUERY, 2, 5, 7, 0, 0, 0, ONE, ONE, ONE));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(rand_fields(MODE_LOAD, $urandom_range(1, SECTORS),
                                       $urandom_range(1, LAYERS),
                                       $urandom_range(1, WIRES_PER_LAYER)));
        3: send_item(rand_fields(MODE_LOAD, $urandom_range(0, 7), $urandom_range(0, 63),
                                 $urandom_range(0, 255)));
        default: send_item(pick_query());
      endcase
    end
  endtask

  // stall the result side while queries stream in back to back
  task automatic test_backpressure();
    tx_gap_max = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 250; i++) send_item(pick_query());
    tx_gap_max = 10;
    rx_gap_max = 10;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unloaded();
    test_geometry();
    test_extremes();
    test_random(1330);
    test_backpressure();
    @(negedge clk);
    push <= 1'b0;
    wait (pending_doca.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
